>>> hdl/dnep_pkg.sv
// ----------------------------------------------------------------------------
// dnep_pkg: shared types and character tables for the DN unescape block
// Holds the item structs, the status and phase codes, the character constants
// and the character class functions used by the decode stage.
// ----------------------------------------------------------------------------
package dnep_pkg;

  localparam int unsigned CharW = 16;
  localparam int unsigned ByteW = 7;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } in_item_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BADHEX   = 2'd2,
    ST_NONPRINT = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    status_e          status;
    logic             end_of_string;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'b001,
    PH_ESCAPE = 3'b010,
    PH_HEX    = 3'b100
  } phase_e;

  localparam logic [CharW-1:0] ChBackslash = 16'h005C;
  localparam logic [CharW-1:0] ChComma     = 16'h002C;
  localparam logic [CharW-1:0] ChPlus      = 16'h002B;
  localparam logic [CharW-1:0] ChQuote     = 16'h0022;
  localparam logic [CharW-1:0] ChLess      = 16'h003C;
  localparam logic [CharW-1:0] ChGreater   = 16'h003E;
  localparam logic [CharW-1:0] ChSemicolon = 16'h003B;

  function automatic logic is_special(input logic [CharW-1:0] c);
    return (c == ChComma) || (c == ChPlus) || (c == ChQuote) || (c == ChBackslash) ||
           (c == ChLess) || (c == ChGreater) || (c == ChSemicolon);
  endfunction

  function automatic logic is_printable(input logic [CharW-1:0] c);
    logic [ByteW-1:0] b;
    logic             ok;
    b = c[ByteW-1:0];
    ok = 1'b0;
    if (c[CharW-1:ByteW] == '0) begin
      ok = (b inside {[7'h41:7'h5A], [7'h61:7'h7A], [7'h30:7'h39],
                      7'h20, 7'h27, 7'h28, 7'h29, 7'h2B, 7'h2C,
                      7'h2D, 7'h2E, 7'h2F, 7'h3A, 7'h3D, 7'h3F});
    end
    return ok;
  endfunction

  // Bit 4 set means the unit is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [CharW-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[16'h0030:16'h0039]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[16'h0041:16'h0046], [16'h0061:16'h0066]}) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

>>> hdl/dnep_in_stage.sv
// ----------------------------------------------------------------------------
// dnep_in_stage: input register
// Captures one item from the input channel and holds it until the decode
// stage takes it.
// ----------------------------------------------------------------------------
module dnep_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dnep_pkg::in_item_t in_item_i,
  output logic               held_valid_o,
  output dnep_pkg::in_item_t held_item_o,
  input  logic               take_i
);

  logic               valid_q;
  dnep_pkg::in_item_t item_q;

  assign in_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

endmodule

>>> hdl/dnep_decode.sv
// ----------------------------------------------------------------------------
// dnep_decode: escape decoder and result register
// Tracks the escape phase, checks hex pairs and printability, and writes the
// result item into the output register.
// ----------------------------------------------------------------------------
module dnep_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                held_valid_i,
  input  dnep_pkg::in_item_t  held_item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dnep_pkg::out_item_t out_item_o
);

  dnep_pkg::phase_e    phase_q, phase_d;
  logic [4:0]          nib_q, nib_d;
  logic                drop_q, drop_d;
  logic                out_valid_q;
  dnep_pkg::out_item_t out_item_q;

  logic                     fire;
  logic                     want_char, want_err, res_valid;
  dnep_pkg::status_e        err_st;
  logic [dnep_pkg::CharW-1:0] char_val;
  logic [4:0]               lo_nib;
  dnep_pkg::out_item_t      res;
  logic                     last;
  logic [dnep_pkg::CharW-1:0] c;

  assign take_o = !out_valid_q || !out_stall_i;
  assign fire   = held_valid_i && take_o;
  assign c      = held_item_i.char_code;
  assign last   = held_item_i.last_char;
  assign lo_nib = dnep_pkg::hex_value(c);

  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    drop_d    = drop_q;
    want_char = 1'b0;
    want_err  = 1'b0;
    err_st    = dnep_pkg::ST_OK;
    char_val  = c;
    res_valid = 1'b0;
    res       = '{out_byte: '0, byte_valid: 1'b0, status: dnep_pkg::ST_OK,
                  end_of_string: 1'b0};
    if (drop_q) begin
      if (last) begin
        drop_d = 1'b0;
      end
    end else begin
      case (phase_q)
        dnep_pkg::PH_ESCAPE: begin
          if (dnep_pkg::is_special(c)) begin
            want_char = 1'b1;
          end else if (last) begin
            want_err = 1'b1;
            err_st   = dnep_pkg::ST_TRUNC;
          end else begin
            nib_d   = lo_nib;
            phase_d = dnep_pkg::PH_HEX;
          end
        end
        dnep_pkg::PH_HEX: begin
          phase_d = dnep_pkg::PH_NORMAL;
          nib_d   = '0;
          if (nib_q[4] || lo_nib[4]) begin
            want_err = 1'b1;
            err_st   = dnep_pkg::ST_BADHEX;
          end else begin
            want_char = 1'b1;
            char_val  = {8'h00, nib_q[3:0], lo_nib[3:0]};
          end
        end
        default: begin
          phase_d = dnep_pkg::PH_NORMAL;
          if (c == dnep_pkg::ChBackslash) begin
            if (last) begin
              want_err = 1'b1;
              err_st   = dnep_pkg::ST_TRUNC;
            end else begin
              phase_d = dnep_pkg::PH_ESCAPE;
            end
          end else begin
            want_char = 1'b1;
          end
        end
      endcase
      if (want_char) begin
        phase_d = dnep_pkg::PH_NORMAL;
        if (dnep_pkg::is_printable(char_val)) begin
          res_valid = 1'b1;
          res = '{out_byte: char_val[dnep_pkg::ByteW-1:0], byte_valid: 1'b1,
                  status: dnep_pkg::ST_OK, end_of_string: last};
        end else begin
          want_err = 1'b1;
          err_st   = dnep_pkg::ST_NONPRINT;
        end
      end
      if (want_err) begin
        res_valid = 1'b1;
        res = '{out_byte: '0, byte_valid: 1'b0, status: err_st, end_of_string: 1'b1};
        phase_d = dnep_pkg::PH_NORMAL;
        nib_d   = '0;
        drop_d  = !last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dnep_pkg::PH_NORMAL;
      nib_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        nib_q   <= nib_d;
        drop_q  <= drop_d;
      end
      if (take_o) begin
        out_valid_q <= fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_char_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.byte_valid |->
      out_item_q.status == dnep_pkg::ST_OK &&
      dnep_pkg::is_printable({9'h000, out_item_q.out_byte}))
    else $error("emitted byte is not printable or has error status");

  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.status != dnep_pkg::ST_OK |->
      out_item_q.end_of_string && !out_item_q.byte_valid)
    else $error("error item does not end the string");

  a_drop_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> phase_q == dnep_pkg::PH_NORMAL)
    else $error("dropping while inside an escape");

  a_drop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(drop_q) |-> out_valid_q && out_item_q.status != dnep_pkg::ST_OK)
    else $error("dropping started without an error item");

endmodule

>>> hdl/dn_escape_to_printable_unit.sv
// ----------------------------------------------------------------------------
// dn_escape_to_printable_unit: DN string unescape and PrintableString check
// Removes backslash escapes from a stream of UTF-16 code units and emits the
// resulting PrintableString bytes, or an error status that ends the string.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one code unit per item with its last-character
// flag. The output channel carries zero or one result per input item: a byte
// with byte_valid set, or an error status with end_of_string set.
// An item passes through an input register and a result register before its
// result is presented. One item is taken every cycle while the receiver does
// not stall; the escape state (phase, nibble, drop flag) is registered and
// updated as the item leaves the input register. An opening backslash and a
// first hex digit give no result unless flagged last. After an error, items
// are consumed without results up to and including the last-flagged one.
// Reset clears the valid flags of both registers and the escape state.
// When the receiver stalls, the result register holds, the input register
// fills, and then in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
module dn_escape_to_printable_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dnep_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dnep_pkg::out_item_t out_item_o
);

  logic               held_valid;
  dnep_pkg::in_item_t held_item;
  logic               take;

  dnep_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .held_valid_o(held_valid),
    .held_item_o (held_item),
    .take_i      (take)
  );

  dnep_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .held_valid_i(held_valid),
    .held_item_i (held_item),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> verif/dn_escape_to_printable_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dn_escape_to_printable_unit_tb: self-checking bench for the DN unescape unit
// Feeds escaped distinguished-name strings one code unit per item, predicts
// the unescaped PrintableString bytes and error statuses in the bench, and
// compares every result the unit returns, under random source and sink stalls.
// ----------------------------------------------------------------------------
module dn_escape_to_printable_unit_tb;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  dnep_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  dnep_pkg::out_item_t out_item_o;

  dn_escape_to_printable_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  localparam string PrintableSet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 '()+,-./:=?";
  localparam string SpecialSet = ",+\"\\<>;";

  dnep_pkg::phase_e    esc_phase;
  logic [15:0]         held_digit;
  logic                drop_mode;
  dnep_pkg::out_item_t pending_decodes[$];

  int unsigned src_idle_pct;
  int unsigned dst_stall_pct;
  int          hold_left;
  int          items_sent;
  int          errors;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic is_escapable(input logic [15:0] c);
    for (int i = 0; i < SpecialSet.len(); i++) begin
      if (c == 16'(SpecialSet[i])) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic in_printable_set(input logic [15:0] c);
    for (int i = 0; i < PrintableSet.len(); i++) begin
      if (c == 16'(PrintableSet[i])) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [4:0] nibble_of(input logic [15:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return 5'd16;
  endfunction

  function automatic dnep_pkg::out_item_t decode_error(input dnep_pkg::status_e st,
                                                       input logic last);
    dnep_pkg::out_item_t r;
    r = '0;
    r.status = st;
    r.end_of_string = 1'b1;
    esc_phase = dnep_pkg::PH_NORMAL;
    held_digit = '0;
    drop_mode = !last;
    return r;
  endfunction

  function automatic dnep_pkg::out_item_t decode_char(input logic [15:0] c,
                                                      input logic last);
    dnep_pkg::out_item_t r;
    esc_phase = dnep_pkg::PH_NORMAL;
    if (!in_printable_set(c)) return decode_error(dnep_pkg::ST_NONPRINT, last);
    r.out_byte = c[6:0];
    r.byte_valid = 1'b1;
    r.status = dnep_pkg::ST_OK;
    r.end_of_string = last;
    return r;
  endfunction

  function automatic void unescape_predict(input dnep_pkg::in_item_t it);
    logic [15:0] c;
    logic        last;
    logic [4:0]  hi;
    logic [4:0]  lo;
    c = it.char_code;
    last = it.last_char;
    if (drop_mode) begin
      if (last) drop_mode = 1'b0;
      return;
    end
    case (esc_phase)
      dnep_pkg::PH_ESCAPE: begin
        if (is_escapable(c)) begin
          pending_decodes.push_back(decode_char(c, last));
        end else if (last) begin
          pending_decodes.push_back(decode_error(dnep_pkg::ST_TRUNC, last));
        end else begin
          held_digit = c;
          esc_phase = dnep_pkg::PH_HEX;
        end
      end
      dnep_pkg::PH_HEX: begin
        hi = nibble_of(held_digit);
        lo = nibble_of(c);
        held_digit = '0;
        if (hi[4] || lo[4]) begin
          pending_decodes.push_back(decode_error(dnep_pkg::ST_BADHEX, last));
        end else begin
          pending_decodes.push_back(decode_char({8'h00, hi[3:0], lo[3:0]}, last));
        end
      end
      default: begin
        esc_phase = dnep_pkg::PH_NORMAL;
        if (c == dnep_pkg::ChBackslash) begin
          if (last) begin
            pending_decodes.push_back(decode_error(dnep_pkg::ST_TRUNC, last));
          end else begin
            esc_phase = dnep_pkg::PH_ESCAPE;
          end
        end else begin
          pending_decodes.push_back(decode_char(c, last));
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_result(input dnep_pkg::out_item_t got);
    dnep_pkg::out_item_t want;
    if (pending_decodes.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = pending_decodes.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.end_of_string !== want.end_of_string)
      report_mismatch($sformatf("end_of_string %b, want %b", got.end_of_string,
                                want.end_of_string));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result(out_item_o);
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < dst_stall_pct);
    end
  end

  task automatic send_item(input logic [15:0] code, input logic last);
    dnep_pkg::in_item_t it;
    it.char_code = code;
    it.last_char = last;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    unescape_predict(it);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] hex_digit_char(input logic [3:0] n);
    if (n < 10) return 16'("0") + 16'(n);
    if ($urandom_range(1)) return 16'("a") + 16'(n - 10);
    return 16'("A") + 16'(n - 10);
  endfunction

  function automatic logic [15:0] any_digit_char();
    if ($urandom_range(99) < 85) return hex_digit_char(4'($urandom_range(15)));
    return 16'($urandom_range(65535));
  endfunction

  task automatic send_random_string();
    logic [15:0] units[$];
    logic [7:0]  val;
    int          n_tokens;
    int          pick;
    n_tokens = $urandom_range(1, 10);
    for (int t = 0; t < n_tokens; t++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        units.push_back(16'(PrintableSet[$urandom_range(PrintableSet.len() - 1)]));
      end else if (pick < 65) begin
        units.push_back(dnep_pkg::ChBackslash);
        units.push_back(16'(SpecialSet[$urandom_range(SpecialSet.len() - 1)]));
      end else if (pick < 77) begin
        val = 8'($urandom_range(255));
        units.push_back(dnep_pkg::ChBackslash);
        if ($urandom_range(99) < 85) begin
          units.push_back(hex_digit_char(val[7:4]));
          units.push_back(hex_digit_char(val[3:0]));
        end else begin
          units.push_back(any_digit_char());
          units.push_back(any_digit_char());
        end
      end else if (pick < 85) begin
        units.push_back(16'($urandom_range(127)));
      end else if (pick < 92) begin
        units.push_back(16'($urandom_range(65535)));
      end else if (pick < 96) begin
        units.push_back(dnep_pkg::ChBackslash);
        units.push_back(16'($urandom_range(65535)));
      end else begin
        units.push_back(dnep_pkg::ChBackslash);
        break;
      end
    end
    foreach (units[i]) send_item(units[i], i == units.size() - 1);
  endtask

  task automatic test_plain_chars();
    send_item("A", 1'b0);
    send_item("z", 1'b0);
    send_item(" ", 1'b0);
    send_item("?", 1'b1);
    wait_drain();
  endtask

  task automatic test_escaped_specials();
    send_item(dnep_pkg::ChBackslash, 1'b0);
    send_item(dnep_pkg::ChComma, 1'b0);
    send_item(dnep_pkg::ChBackslash, 1'b0);
    send_item(dnep_pkg::ChQuote, 1'b0);
    send_item("x", 1'b0);
    send_item("y", 1'b1);
    wait_drain();
  endtask

  task automatic test_hex_pairs();
    send_item(dnep_pkg::ChBackslash, 1'b0);
    send_item("4", 1'b0);
    send_item("a", 1'b0);
    send_item(dnep_pkg::ChBackslash, 1'b0);
    send_item("g", 1'b0);
    send_item("0", 1'b1);
    wait_drain();
  endtask

  task automatic test_truncated_escape();
    send_item(dnep_pkg::ChBackslash, 1'b1);
    send_item(dnep_pkg::ChBackslash, 1'b0);
    send_item("Q", 1'b1);
    wait_drain();
  endtask

  task automatic test_code_extremes();
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0000, 1'b1);
    send_item(16'h0141, 1'b1);
    wait_drain();
  endtask

  task automatic test_random_strings(input int unsigned src_pct, input int unsigned dst_pct,
                                     input int n_items);
    int stop_at;
    src_idle_pct = src_pct;
    dst_stall_pct = dst_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_string();
    wait_drain();
  endtask

  task automatic test_backpressure_fill();
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_left = 60;
    for (int i = 0; i < 24; i++) begin
      send_item(16'(PrintableSet[$urandom_range(PrintableSet.len() - 1)]), i == 23);
    end
    wait_drain();
  endtask

  task automatic test_pause_until_empty();
    src_idle_pct = 20;
    dst_stall_pct = 50;
    for (int k = 0; k < 6; k++) begin
      send_random_string();
      wait_drain();
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    esc_phase = dnep_pkg::PH_NORMAL;
    held_digit = '0;
    drop_mode = 1'b0;
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_left = 0;
    items_sent = 0;
    errors = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_chars();
    test_escaped_specials();
    test_hex_pairs();
    test_truncated_escape();
    test_code_extremes();
    test_backpressure_fill();
    test_random_strings(34, 74, 400);
    test_random_strings(74, 34, 400);
    test_random_strings(0, 0, 400);
    test_pause_until_empty();

    wait_drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("[dn_escape_to_printable_unit] OK");
    end else begin
      $display("[dn_escape_to_printable_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[dn_escape_to_printable_unit] ERROR");
    $finish;
  end

endmodule
